// ----- rtl/qst_pkg.sv -----
// Shared types and constants for the query string tokenizer.
package qst_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOW_A   = 8'h61;
  localparam logic [7:0] CH_LOW_F   = 8'h66;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] HEX_LETTER_BASE = 8'd10;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DIG1  = 2'd1;
  localparam logic [1:0] PH_DIG2  = 2'd2;

  localparam logic [1:0] KIND_KEY         = 2'd0;
  localparam logic [1:0] KIND_VALUE       = 2'd1;
  localparam logic [1:0] KIND_END_UNNAMED = 2'd2;
  localparam logic [1:0] KIND_END_NAMED   = 2'd3;

  typedef struct packed {
    logic [1:0] escape_phase;
    logic [7:0] escape_accum;
    logic       in_value_part;
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } result_t;

  localparam state_t STATE_RESET = '{escape_phase: PH_IDLE, escape_accum: 8'd0,
                                     in_value_part: 1'b0};

endpackage

// ----- rtl/qst_step.sv -----
// Per-byte percent decoding and key/value split for one request.
module qst_step (
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  input  qst_pkg::state_t  state,
  output qst_pkg::state_t  state_nxt,
  output logic [1:0]       res_cnt,
  output qst_pkg::result_t res0,
  output qst_pkg::result_t res1
);

  logic [7:0]       digit;
  logic [7:0]       acc;
  logic [7:0]       dec;
  logic             have;
  logic             have_res;
  qst_pkg::state_t  st;
  qst_pkg::result_t split_res;
  qst_pkg::result_t end_res;

  always_comb begin
    if (in_byte >= qst_pkg::CH_LOW_A && in_byte <= qst_pkg::CH_LOW_F) begin
      digit = in_byte - qst_pkg::CH_LOW_A + qst_pkg::HEX_LETTER_BASE;
    end else if (in_byte >= qst_pkg::CH_UP_A && in_byte <= qst_pkg::CH_UP_F) begin
      digit = in_byte - qst_pkg::CH_UP_A + qst_pkg::HEX_LETTER_BASE;
    end else begin
      digit = in_byte - qst_pkg::CH_ZERO;
    end
  end

  assign acc = {state.escape_accum[3:0], 4'b0000} + digit;

  always_comb begin
    st        = state;
    have      = 1'b0;
    dec       = in_byte;
    have_res  = 1'b0;
    split_res = '{kind: qst_pkg::KIND_KEY, data: 8'd0, last: 1'b0};

    if (state.escape_phase == qst_pkg::PH_IDLE) begin
      if (in_byte == qst_pkg::CH_PERCENT) begin
        st.escape_phase = qst_pkg::PH_DIG1;
        st.escape_accum = 8'd0;
      end else begin
        have = 1'b1;
      end
    end else begin
      st.escape_accum = acc;
      if (state.escape_phase == qst_pkg::PH_DIG1) begin
        st.escape_phase = qst_pkg::PH_DIG2;
      end else begin
        // Phase two, and the unreachable phase three, complete the escape.
        st.escape_phase = qst_pkg::PH_IDLE;
        dec  = acc;
        have = 1'b1;
      end
    end

    if (have) begin
      if (!state.in_value_part) begin
        if (dec == qst_pkg::CH_EQUALS) begin
          st.in_value_part = 1'b1;
        end else if (dec == qst_pkg::CH_AMP) begin
          have_res       = 1'b1;
          split_res.kind = qst_pkg::KIND_END_UNNAMED;
        end else begin
          have_res       = 1'b1;
          split_res.kind = qst_pkg::KIND_KEY;
          split_res.data = dec;
        end
      end else begin
        have_res = 1'b1;
        if (dec == qst_pkg::CH_AMP) begin
          split_res.kind   = qst_pkg::KIND_END_NAMED;
          st.in_value_part = 1'b0;
        end else begin
          split_res.kind = qst_pkg::KIND_VALUE;
          split_res.data = dec;
        end
      end
    end
  end

  always_comb begin
    end_res.kind = st.in_value_part ? qst_pkg::KIND_END_NAMED : qst_pkg::KIND_END_UNNAMED;
    end_res.data = 8'd0;
    end_res.last = 1'b1;

    res1      = end_res;
    state_nxt = st;
    if (in_last) begin
      state_nxt = qst_pkg::STATE_RESET;
      if (have_res) begin
        res0    = split_res;
        res_cnt = 2'd2;
      end else begin
        res0    = end_res;
        res_cnt = 2'd1;
      end
    end else begin
      res0      = split_res;
      res0.last = 1'b1;
      res_cnt   = have_res ? 2'd1 : 2'd0;
    end
  end

endmodule

// ----- rtl/query_string_tokenizer.sv -----
// Query string tokenizer top level: state, result buffer and handshakes.
// Results are registered: a request's first result is valid in the cycle after it is accepted.
// One byte per cycle is taken while each byte gives at most one result and the
// receiver takes each result; a byte that gives two results (a final byte that also
// decodes to a result) holds the input while the two-entry result buffer drains.
// Reset (rst_n low, synchronous) clears the escape state, the value flag and
// the result buffer.
module query_string_tokenizer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  qst_pkg::state_t  state_r;
  qst_pkg::state_t  state_nxt;
  qst_pkg::result_t buf0_r;
  qst_pkg::result_t buf1_r;
  logic [1:0]       cnt_r;
  logic [1:0]       res_cnt;
  qst_pkg::result_t res0;
  qst_pkg::result_t res1;
  logic             in_fire;
  logic             out_fire;

  qst_step u_step (
    .in_byte   (in_byte),
    .in_last   (in_last),
    .state     (state_r),
    .state_nxt (state_nxt),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  assign out_valid = (cnt_r != 2'd0);
  assign out_kind  = buf0_r.kind;
  assign out_byte  = buf0_r.data;
  assign out_last  = buf0_r.last;
  assign out_fire  = out_valid && out_ready;

  // The buffer takes a new request once it is empty after this cycle's pop.
  assign in_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qst_pkg::STATE_RESET;
      cnt_r   <= 2'd0;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
        cnt_r   <= res_cnt;
      end else if (out_fire) begin
        cnt_r   <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      buf0_r <= res0;
      buf1_r <= res1;
    end else if (out_fire) begin
      buf0_r <= buf1_r;
    end
  end

endmodule

// ----- test/tb_query_string_tokenizer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the query string tokenizer: directed and random query strings.
module tb_query_string_tokenizer;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;
  localparam logic [7:0] CH_PLUS = 8'h2B;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic in_last = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic out_last;

  query_string_tokenizer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  always #4 clk = ~clk;

  // Predictor state, mirrors the block's escape and key/value tracking.
  logic [1:0] esc_phase = qst_pkg::PH_IDLE;
  logic [7:0] esc_accum = 8'd0;
  logic       in_value = 1'b0;

  qst_pkg::result_t pending_tokens[$];
  logic [7:0] query_bytes[$];
  int         mismatches = 0;
  int         cycle_count = 0;
  int         sent_items = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;
  int         hold_left = 0;

  function automatic int send_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return 73;
      IDLE_BOTH:   return 15;
      default:     return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 73;
      IDLE_BOTH:     return 15;
      default:       return 0;
    endcase
  endfunction

  function automatic logic [7:0] digit_weight(logic [7:0] c);
    if (c >= qst_pkg::CH_LOW_A && c <= qst_pkg::CH_LOW_F)
      return c - qst_pkg::CH_LOW_A + qst_pkg::HEX_LETTER_BASE;
    if (c >= qst_pkg::CH_UP_A && c <= qst_pkg::CH_UP_F)
      return c - qst_pkg::CH_UP_A + qst_pkg::HEX_LETTER_BASE;
    return c - qst_pkg::CH_ZERO;
  endfunction

  function automatic void append_token(qst_pkg::result_t t);
    pending_tokens.insert(pending_tokens.size(), t);
  endfunction

  function automatic void add_query_byte(logic [7:0] b);
    query_bytes.insert(query_bytes.size(), b);
  endfunction

  function automatic void push_token(logic [1:0] kind, logic [7:0] data);
    qst_pkg::result_t t;
    t.kind = kind;
    t.data = data;
    t.last = 1'b0;
    append_token(t);
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic is_last);
    logic [7:0] d;
    logic have;
    int first;
    qst_pkg::result_t t;
    first = pending_tokens.size();
    have = 1'b0;
    d = 8'd0;
    if (esc_phase == qst_pkg::PH_IDLE) begin
      if (c == qst_pkg::CH_PERCENT) begin
        esc_phase = qst_pkg::PH_DIG1;
        esc_accum = 8'd0;
      end else begin
        d = c;
        have = 1'b1;
      end
    end else begin
      esc_accum = {esc_accum[3:0], 4'h0} + digit_weight(c);
      if (esc_phase == qst_pkg::PH_DIG1) begin
        esc_phase = qst_pkg::PH_DIG2;
      end else begin
        d = esc_accum;
        have = 1'b1;
        esc_phase = qst_pkg::PH_IDLE;
      end
    end
    // A decoded separator acts the same whether it was escaped or not.
    if (have) begin
      if (!in_value) begin
        if (d == qst_pkg::CH_EQUALS) in_value = 1'b1;
        else if (d == qst_pkg::CH_AMP) push_token(qst_pkg::KIND_END_UNNAMED, 8'd0);
        else push_token(qst_pkg::KIND_KEY, d);
      end else if (d == qst_pkg::CH_AMP) begin
        push_token(qst_pkg::KIND_END_NAMED, 8'd0);
        in_value = 1'b0;
      end else begin
        push_token(qst_pkg::KIND_VALUE, d);
      end
    end
    if (is_last) begin
      push_token(in_value ? qst_pkg::KIND_END_NAMED : qst_pkg::KIND_END_UNNAMED, 8'd0);
      esc_phase = qst_pkg::PH_IDLE;
      esc_accum = 8'd0;
      in_value = 1'b0;
    end
    if (pending_tokens.size() > first) begin
      t = pending_tokens.pop_back();
      t.last = 1'b1;
      append_token(t);
    end
  endfunction

  task automatic send_request(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tokenize_byte(b, is_last);
    sent_items++;
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 10) return qst_pkg::CH_ZERO + n;
    return ($urandom_range(1) ? qst_pkg::CH_UP_A : qst_pkg::CH_LOW_A) + n
           - qst_pkg::HEX_LETTER_BASE;
  endfunction

  function automatic void add_content_byte();
    int pick;
    logic [7:0] v;
    pick = $urandom_range(9);
    if (pick < 6) begin
      case ($urandom_range(2))
        0: add_query_byte(8'($urandom_range(8'h61, 8'h7A)));
        1: add_query_byte(8'($urandom_range(8'h41, 8'h5A)));
        default: add_query_byte(8'($urandom_range(8'h30, 8'h39)));
      endcase
    end else if (pick < 8) begin
      v = 8'($urandom_range(255));
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: v = qst_pkg::CH_EQUALS;
          1: v = qst_pkg::CH_AMP;
          default: v = qst_pkg::CH_PERCENT;
        endcase
      end
      add_query_byte(qst_pkg::CH_PERCENT);
      add_query_byte(hex_char(v[7:4]));
      add_query_byte(hex_char(v[3:0]));
    end else if (pick == 8) begin
      add_query_byte(CH_PLUS);
    end else begin
      add_query_byte(8'($urandom_range(255)));
    end
  endfunction

  // Mostly well-formed strings; a tenth are raw noise and a tenth end mid-escape.
  task automatic send_query();
    int shape;
    int n;
    shape = $urandom_range(9);
    query_bytes.delete();
    if (shape == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) add_query_byte(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 4);
      for (int p = 0; p < n; p++) begin
        if (p > 0) add_query_byte(qst_pkg::CH_AMP);
        repeat ($urandom_range(4)) add_content_byte();
        if ($urandom_range(3) != 0) begin
          add_query_byte(qst_pkg::CH_EQUALS);
          repeat ($urandom_range(5)) add_content_byte();
        end
      end
      if (shape == 1) begin
        add_query_byte(qst_pkg::CH_PERCENT);
        if ($urandom_range(1)) add_query_byte(hex_char(4'($urandom_range(15))));
      end
      if (query_bytes.size() == 0) add_content_byte();
    end
    for (int i = 0; i < query_bytes.size(); i++)
      send_request(query_bytes[i], i == query_bytes.size() - 1);
  endtask

  task automatic test_directed();
    idle_mode = IDLE_NONE;
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b1);
    send_request(qst_pkg::CH_AMP, 1'b1);
    send_request("k", 1'b0);
    send_request(qst_pkg::CH_EQUALS, 1'b0);
    send_request(qst_pkg::CH_EQUALS, 1'b0);
    send_request(qst_pkg::CH_AMP, 1'b0);
    // Escaped separators, then an escaped percent that stays data.
    send_request(qst_pkg::CH_PERCENT, 1'b0);
    send_request("3", 1'b0);
    send_request("D", 1'b0);
    send_request(qst_pkg::CH_PERCENT, 1'b0);
    send_request("2", 1'b0);
    send_request("6", 1'b0);
    send_request(qst_pkg::CH_PERCENT, 1'b0);
    send_request("2", 1'b0);
    send_request("5", 1'b0);
    send_request(qst_pkg::CH_PERCENT, 1'b0);
    send_request("z", 1'b0);
    send_request("f", 1'b0);
    send_request(qst_pkg::CH_PERCENT, 1'b1);
    send_request(qst_pkg::CH_PERCENT, 1'b0);
    send_request("4", 1'b1);
    send_request(qst_pkg::CH_EQUALS, 1'b1);
    release_input();
  endtask

  task automatic test_random(input idle_mode_t mode, input int target);
    int start;
    idle_mode = mode;
    start = sent_items;
    while (sent_items - start < target) send_query();
    release_input();
  endtask

  task automatic test_backpressure();
    int start;
    idle_mode = IDLE_NONE;
    hold_req <= 1'b1;
    start = sent_items;
    while (sent_items - start < 60) send_query();
    release_input();
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct());
    end
  end

  always @(posedge clk) begin
    qst_pkg::result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected token: kind %0d byte %02h last %0d", out_kind, out_byte,
                   out_last);
      end else begin
        want = pending_tokens.pop_front();
        if (out_kind !== want.kind || out_byte !== want.data || out_last !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("token mismatch: expected kind %0d byte %02h last %0d, got %0d %02h %0d",
                     want.kind, want.data, want.last, out_kind, out_byte, out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL query_string_tokenizer");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(IDLE_NONE, 220);
    test_random(IDLE_SENDER, 220);
    test_random(IDLE_RECEIVER, 220);
    test_random(IDLE_BOTH, 220);
    test_backpressure();
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("PASS query_string_tokenizer");
    end else begin
      $display("FAIL query_string_tokenizer");
    end
    $finish;
  end

endmodule
